### design/planar_pose_integrator_top_defines.svh
// Assertion macros shared by the pose integrator modules.
`ifndef PLANAR_POSE_INTEGRATOR_TOP_DEFINES_SVH
`define PLANAR_POSE_INTEGRATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PPI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PPI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ppi_pkg.sv
// Shared constants, types and tables of the planar pose integrator.
package ppi_pkg;

  // Field widths
  localparam int VF_W  = 24;
  localparam int VS_W  = 24;
  localparam int YR_W  = 32;
  localparam int DT_W  = 24;
  localparam int POS_W = 48;
  localparam int HDG_W = 32;
  localparam int QT_W  = 18;

  // Input word layout, lowest bit first
  localparam int VF_LSB = 0;
  localparam int VS_LSB = VF_LSB + VF_W;
  localparam int YR_LSB = VS_LSB + VS_W;
  localparam int DT_LSB = YR_LSB + YR_W;
  localparam int NX_LSB = DT_LSB + DT_W;
  localparam int NY_LSB = NX_LSB + POS_W;
  localparam int NH_LSB = NY_LSB + POS_W;
  localparam int IN_TDATA_W = NH_LSB + HDG_W;

  // Output word layout, lowest bit first
  localparam int PX_LSB = 0;
  localparam int PY_LSB = PX_LSB + POS_W;
  localparam int HD_LSB = PY_LSB + POS_W;
  localparam int QZ_LSB = HD_LSB + HDG_W;
  localparam int QW_LSB = QZ_LSB + QT_W;
  localparam int OUT_USED_W = QW_LSB + QT_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // CORDIC
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int CRD_W = 34;
  localparam int ATAN_IW = 5;
  localparam logic signed [CRD_W-1:0] CORDIC_GAIN = CRD_W'(652032874);

  // Serial multiply: one multiplier bit per cycle, MSB first
  localparam int MUL_STEPS = 24;
  localparam int CNT_W = $clog2(MUL_STEPS);

  // Rounding shifts
  localparam int VEL_SH = 16;
  localparam int POS_SH = 26;
  localparam int HDG_SH = 12;
  localparam int QT_SH  = 14;
  localparam int QT_MAX = 65536;

  // Step controls of one multiply-accumulate lane
  typedef struct packed {
    logic en;
    logic first;
    logic neg;
  } mac_ctl_t;

  // Arctangent of 2^-k in binary-angle units
  function automatic logic [HDG_W-1:0] atan_turn(input logic [ATAN_IW-1:0] k);
    logic [HDG_W-1:0] a;
    case (k)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Round a Q3.30 value to Q1.16, round half up, saturate to +/- one
  function automatic logic [QT_W-1:0] quat_term(input logic signed [CRD_W-1:0] v);
    logic signed [CRD_W-1:0] q;
    logic [QT_W-1:0] r;
    q = v >>> QT_SH;
    q = q + (v[QT_SH-1] ? CRD_W'(1) : CRD_W'(0));
    if (q > QT_MAX) begin
      r = QT_W'(QT_MAX);
    end else if (q < -QT_MAX) begin
      r = QT_W'(-QT_MAX);
    end else begin
      r = q[QT_W-1:0];
    end
    return r;
  endfunction

endpackage

### design/ppi_mac_lane.sv
// Bit-serial multiply-accumulate lane, multiplier bits MSB first.
module ppi_mac_lane import ppi_pkg::*; #(
  parameter int MW = 34,
  parameter int AW = 60
) (
  input  logic                 clk,
  input  mac_ctl_t             ctl,
  input  logic                 b0,
  input  logic signed [MW-1:0] v0,
  input  logic                 b1,
  input  logic signed [MW-1:0] v1,
  input  logic                 sub1,
  output logic signed [AW-1:0] acc_o
);

  localparam int TW = MW + 2;

  logic signed [TW-1:0] t0, t1, sum, term;
  logic signed [AW-1:0] acc_r, acc_nxt, term_ext;

  always_comb begin
    t0 = b0 ? {{2{v0[MW-1]}}, v0} : '0;
    t1 = b1 ? {{2{v1[MW-1]}}, v1} : '0;
    sum = sub1 ? t0 - t1 : t0 + t1;
    // MSB of a signed multiplier carries negative weight
    term = ctl.neg ? -sum : sum;
    term_ext = {{(AW-TW){term[TW-1]}}, term};
    acc_nxt = ctl.first ? term_ext : (acc_r <<< 1) + term_ext;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_o = acc_r;

endmodule

### design/ppi_cordic.sv
// Iterative rotation-mode CORDIC: cosine and sine of a binary angle.
`include "planar_pose_integrator_top_defines.svh"

module ppi_cordic import ppi_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [HDG_W-1:0]        angle,
  output logic                    done,
  output logic signed [CRD_W-1:0] cos_o,
  output logic signed [CRD_W-1:0] sin_o
);

  localparam int IW = $clog2(STEPS);

  logic                    run_r, run_nxt;
  logic                    done_r, done_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic                    flip_r, flip_nxt;
  logic signed [CRD_W-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic [HDG_W-1:0]        z_r, z_nxt, at;
  logic                    last;

  assign last = (idx_r == IW'(STEPS - 1));

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    idx_nxt  = idx_r;
    flip_nxt = flip_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    xs       = y_r >>> idx_r;
    ys       = x_r >>> idx_r;
    at       = atan_turn(ATAN_IW'(idx_r));
    if (start) begin
      // Fold the left half plane over by half a turn; negate at the end
      flip_nxt = angle[HDG_W-1] ^ angle[HDG_W-2];
      z_nxt    = flip_nxt ? {~angle[HDG_W-1], angle[HDG_W-2:0]} : angle;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      idx_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (!z_r[HDG_W-1]) begin
        x_nxt = x_r - xs;
        y_nxt = y_r + ys;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + xs;
        y_nxt = y_r - ys;
        z_nxt = z_r + at;
      end
      if (last) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flip_r <= flip_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign done  = done_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

  `PPI_ASSERT_IMP(a_crd_no_restart, run_r, !start, "CORDIC restarted while busy")
  `PPI_ASSERT_NXT(a_crd_start_runs, start, run_r && (idx_r == '0), "CORDIC did not start")

endmodule

### design/planar_pose_integrator_top.sv
// Top level of the planar pose integrator: control, serial datapath and ports.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------------
//  in_     | in  | in_tvalid / in_tready | tdata: vel_forward, vel_side, yaw_rate,
//          |     |                       |   elapsed_time, new_x, new_y, new_heading
//          |     |                       | tuser: req_type (1 = set pose)
//  out_    | out | out_tvalid/out_tready | tdata: pos_x, pos_y, heading, quat_z, quat_w
//
//  Velocity word: two CORDIC passes (old heading, then half the new heading) plus two
//    bit-serial multiply passes (rotation, then scale by elapsed time).
//  Set-pose word: one CORDIC pass for the quaternion.
//  One word is in flight at a time; the output register lets the next word in
//    while a finished result waits for out_tready.
//  Reset (rst_n low, synchronous) clears pose to zero and empties the output.
`include "planar_pose_integrator_top_defines.svh"

module planar_pose_integrator_top import ppi_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // vel_forward[23:0], vel_side[47:24], yaw_rate[79:48], elapsed_time[103:80],
  // new_x[151:104], new_y[199:152], new_heading[231:200]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pos_x[47:0], pos_y[95:48], heading[127:96], quat_z[145:128], quat_w[163:146],
  // zero fill[167:164]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Lane widths: rotation lanes carry vf*cos - vs*sin and vf*sin + vs*cos, scale lanes carry v*dt
  localparam int ROT_AW = CRD_W + 2 + MUL_STEPS;
  localparam int VW     = ROT_AW - VEL_SH;
  localparam int SCL_AW = VW + 2 + MUL_STEPS;
  localparam int HDG_AW = YR_W + 2 + MUL_STEPS;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SIN    = 9'b000000010,
    S_ROT    = 9'b000000100,
    S_RND    = 9'b000001000,
    S_SCALE  = 9'b000010000,
    S_UPD    = 9'b000100000,
    S_QSTART = 9'b001000000,
    S_QUAT   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic cnt_last;

  logic in_acc, out_load, out_valid_r, out_valid_nxt;

  // Digit shift registers: multiplier bits leave from the top
  logic [VF_W-1:0] vf_sr_r;
  logic [VS_W-1:0] vs_sr_r;
  logic [DT_W-1:0] dt_sr_r;
  logic signed [YR_W-1:0] yr_r;
  logic signed [VW-1:0] vx_r, vy_r;

  logic [POS_W-1:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic [HDG_W-1:0] pose_h_r, pose_h_nxt;

  logic [POS_W-1:0] out_px_r, out_py_r;
  logic [HDG_W-1:0] out_h_r;
  logic [QT_W-1:0]  out_qz_r, out_qw_r;

  logic                    cor_start, cor_done;
  logic [HDG_W-1:0]        cor_angle;
  logic signed [CRD_W-1:0] cor_cos, cor_sin;

  mac_ctl_t rot_ctl, scl_ctl;
  logic signed [ROT_AW-1:0] acc_vx, acc_vy;
  logic signed [SCL_AW-1:0] acc_dx, acc_dy, dx_sh, dy_sh;
  logic signed [HDG_AW-1:0] acc_dh, dh_sh;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign cnt_last  = (cnt_r == CNT_W'(MUL_STEPS - 1));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tuser ? S_QSTART : S_SIN;
        end
      end
      S_SIN: begin
        if (cor_done) begin
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        cnt_nxt = cnt_last ? '0 : cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cnt_nxt = cnt_last ? '0 : cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_QSTART;
      end
      S_QSTART: begin
        state_nxt = S_QUAT;
      end
      S_QUAT: begin
        if (cor_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Rotate by the old heading on a velocity word, then the half heading for the quaternion
  assign cor_start = (in_acc && !in_tuser) || (state_r == S_QSTART);
  assign cor_angle = (state_r == S_IDLE) ? pose_h_r : {1'b0, pose_h_r[HDG_W-1:1]};

  ppi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  // Rotation pass: signed multiplier bits, MSB step negated
  always_comb begin
    rot_ctl.en    = (state_r == S_ROT);
    rot_ctl.first = (cnt_r == '0);
    rot_ctl.neg   = (cnt_r == '0);
    scl_ctl.en    = (state_r == S_SCALE);
    scl_ctl.first = (cnt_r == '0);
    scl_ctl.neg   = 1'b0;
  end

  ppi_mac_lane #(.MW(CRD_W), .AW(ROT_AW)) u_lane_vx (
    .clk(clk), .ctl(rot_ctl),
    .b0(vf_sr_r[VF_W-1]), .v0(cor_cos),
    .b1(vs_sr_r[VS_W-1]), .v1(cor_sin), .sub1(1'b1),
    .acc_o(acc_vx)
  );

  ppi_mac_lane #(.MW(CRD_W), .AW(ROT_AW)) u_lane_vy (
    .clk(clk), .ctl(rot_ctl),
    .b0(vf_sr_r[VF_W-1]), .v0(cor_sin),
    .b1(vs_sr_r[VS_W-1]), .v1(cor_cos), .sub1(1'b0),
    .acc_o(acc_vy)
  );

  // Scale pass: unsigned elapsed-time bits drive all three lanes
  ppi_mac_lane #(.MW(VW), .AW(SCL_AW)) u_lane_dx (
    .clk(clk), .ctl(scl_ctl),
    .b0(dt_sr_r[DT_W-1]), .v0(vx_r),
    .b1(1'b0), .v1('0), .sub1(1'b0),
    .acc_o(acc_dx)
  );

  ppi_mac_lane #(.MW(VW), .AW(SCL_AW)) u_lane_dy (
    .clk(clk), .ctl(scl_ctl),
    .b0(dt_sr_r[DT_W-1]), .v0(vy_r),
    .b1(1'b0), .v1('0), .sub1(1'b0),
    .acc_o(acc_dy)
  );

  ppi_mac_lane #(.MW(YR_W), .AW(HDG_AW)) u_lane_dh (
    .clk(clk), .ctl(scl_ctl),
    .b0(dt_sr_r[DT_W-1]), .v0(yr_r),
    .b1(1'b0), .v1('0), .sub1(1'b0),
    .acc_o(acc_dh)
  );

  // Round half up folds into the pose add as a carry-in
  assign dx_sh = acc_dx >>> POS_SH;
  assign dy_sh = acc_dy >>> POS_SH;
  assign dh_sh = acc_dh >>> HDG_SH;

  always_comb begin
    pose_x_nxt = pose_x_r;
    pose_y_nxt = pose_y_r;
    pose_h_nxt = pose_h_r;
    if (in_acc && in_tuser) begin
      pose_x_nxt = in_tdata[NX_LSB +: POS_W];
      pose_y_nxt = in_tdata[NY_LSB +: POS_W];
      pose_h_nxt = in_tdata[NH_LSB +: HDG_W];
    end else if (state_r == S_UPD) begin
      pose_x_nxt = pose_x_r + dx_sh[POS_W-1:0] + POS_W'(acc_dx[POS_SH-1]);
      pose_y_nxt = pose_y_r + dy_sh[POS_W-1:0] + POS_W'(acc_dy[POS_SH-1]);
      pose_h_nxt = pose_h_r + dh_sh[HDG_W-1:0] + HDG_W'(acc_dh[HDG_SH-1]);
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      pose_h_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pose_x_r    <= pose_x_nxt;
      pose_y_r    <= pose_y_nxt;
      pose_h_r    <= pose_h_nxt;
    end
  end

  // Operand capture, digit shifting, velocity rounding, result hold
  always_ff @(posedge clk) begin
    if (in_acc) begin
      vf_sr_r <= in_tdata[VF_LSB +: VF_W];
      vs_sr_r <= in_tdata[VS_LSB +: VS_W];
      yr_r    <= in_tdata[YR_LSB +: YR_W];
      dt_sr_r <= in_tdata[DT_LSB +: DT_W];
    end else if (state_r == S_ROT) begin
      vf_sr_r <= {vf_sr_r[VF_W-2:0], 1'b0};
      vs_sr_r <= {vs_sr_r[VS_W-2:0], 1'b0};
    end else if (state_r == S_SCALE) begin
      dt_sr_r <= {dt_sr_r[DT_W-2:0], 1'b0};
    end
    if (state_r == S_RND) begin
      vx_r <= acc_vx[ROT_AW-1:VEL_SH] + VW'(acc_vx[VEL_SH-1]);
      vy_r <= acc_vy[ROT_AW-1:VEL_SH] + VW'(acc_vy[VEL_SH-1]);
    end
    if (out_load) begin
      out_px_r <= pose_x_r;
      out_py_r <= pose_y_r;
      out_h_r  <= pose_h_r;
      out_qz_r <= quat_term(cor_sin);
      out_qw_r <= quat_term(cor_cos);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0),
                       out_qw_r, out_qz_r, out_h_r, out_py_r, out_px_r};

  `PPI_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "took two words")
  `PPI_ASSERT_NXT(a_result_shown, out_load, out_tvalid, "result not presented")
  `PPI_ASSERT_IMP(a_cordic_done_waited, cor_done, (state_r == S_SIN) || (state_r == S_QUAT),
    "CORDIC finished outside a wait state")

endmodule
